@@ design/sfe_pkg.sv @@
// Shared constants, types and the biphase-mark table for the S/PDIF frame encoder.
package sfe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 17;
    localparam int WORD_W   = 32;
    localparam int AUX_W    = 16;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;
    localparam logic [AUX_W-1:0]  AUX_BITS   = 16'hb333;
    localparam logic [AUX_W-1:0]  AUX_FLIP   = 16'h7fff;
    localparam logic [WORD_W-1:0] PRE_B      = 32'hCCE80000;
    localparam logic [WORD_W-1:0] PRE_M      = 32'hCCE20000;
    localparam logic [WORD_W-1:0] PRE_W      = 32'hCCE40000;

    // Per-frame control that rides next to the lanes
    typedef struct packed {
        logic block_start;  // frame 0 of a block: left gets preamble B
        logic chunk_end;
    } t_frame_ctl;

    // Biphase-mark pattern of one byte
    localparam logic [15:0] BMC_TABLE [0:255] = '{
        16'hcccc, 16'h4ccc, 16'h2ccc, 16'haccc, 16'h34cc, 16'hb4cc, 16'hd4cc, 16'h54cc,
        16'h32cc, 16'hb2cc, 16'hd2cc, 16'h52cc, 16'hcacc, 16'h4acc, 16'h2acc, 16'haacc,
        16'h334c, 16'hb34c, 16'hd34c, 16'h534c, 16'hcb4c, 16'h4b4c, 16'h2b4c, 16'hab4c,
        16'hcd4c, 16'h4d4c, 16'h2d4c, 16'had4c, 16'h354c, 16'hb54c, 16'hd54c, 16'h554c,
        16'h332c, 16'hb32c, 16'hd32c, 16'h532c, 16'hcb2c, 16'h4b2c, 16'h2b2c, 16'hab2c,
        16'hcd2c, 16'h4d2c, 16'h2d2c, 16'had2c, 16'h352c, 16'hb52c, 16'hd52c, 16'h552c,
        16'hccac, 16'h4cac, 16'h2cac, 16'hacac, 16'h34ac, 16'hb4ac, 16'hd4ac, 16'h54ac,
        16'h32ac, 16'hb2ac, 16'hd2ac, 16'h52ac, 16'hcaac, 16'h4aac, 16'h2aac, 16'haaac,
        16'h3334, 16'hb334, 16'hd334, 16'h5334, 16'hcb34, 16'h4b34, 16'h2b34, 16'hab34,
        16'hcd34, 16'h4d34, 16'h2d34, 16'had34, 16'h3534, 16'hb534, 16'hd534, 16'h5534,
        16'hccb4, 16'h4cb4, 16'h2cb4, 16'hacb4, 16'h34b4, 16'hb4b4, 16'hd4b4, 16'h54b4,
        16'h32b4, 16'hb2b4, 16'hd2b4, 16'h52b4, 16'hcab4, 16'h4ab4, 16'h2ab4, 16'haab4,
        16'hccd4, 16'h4cd4, 16'h2cd4, 16'hacd4, 16'h34d4, 16'hb4d4, 16'hd4d4, 16'h54d4,
        16'h32d4, 16'hb2d4, 16'hd2d4, 16'h52d4, 16'hcad4, 16'h4ad4, 16'h2ad4, 16'haad4,
        16'h3354, 16'hb354, 16'hd354, 16'h5354, 16'hcb54, 16'h4b54, 16'h2b54, 16'hab54,
        16'hcd54, 16'h4d54, 16'h2d54, 16'had54, 16'h3554, 16'hb554, 16'hd554, 16'h5554,
        16'h3332, 16'hb332, 16'hd332, 16'h5332, 16'hcb32, 16'h4b32, 16'h2b32, 16'hab32,
        16'hcd32, 16'h4d32, 16'h2d32, 16'had32, 16'h3532, 16'hb532, 16'hd532, 16'h5532,
        16'hccb2, 16'h4cb2, 16'h2cb2, 16'hacb2, 16'h34b2, 16'hb4b2, 16'hd4b2, 16'h54b2,
        16'h32b2, 16'hb2b2, 16'hd2b2, 16'h52b2, 16'hcab2, 16'h4ab2, 16'h2ab2, 16'haab2,
        16'hccd2, 16'h4cd2, 16'h2cd2, 16'hacd2, 16'h34d2, 16'hb4d2, 16'hd4d2, 16'h54d2,
        16'h32d2, 16'hb2d2, 16'hd2d2, 16'h52d2, 16'hcad2, 16'h4ad2, 16'h2ad2, 16'haad2,
        16'h3352, 16'hb352, 16'hd352, 16'h5352, 16'hcb52, 16'h4b52, 16'h2b52, 16'hab52,
        16'hcd52, 16'h4d52, 16'h2d52, 16'had52, 16'h3552, 16'hb552, 16'hd552, 16'h5552,
        16'hccca, 16'h4cca, 16'h2cca, 16'hacca, 16'h34ca, 16'hb4ca, 16'hd4ca, 16'h54ca,
        16'h32ca, 16'hb2ca, 16'hd2ca, 16'h52ca, 16'hcaca, 16'h4aca, 16'h2aca, 16'haaca,
        16'h334a, 16'hb34a, 16'hd34a, 16'h534a, 16'hcb4a, 16'h4b4a, 16'h2b4a, 16'hab4a,
        16'hcd4a, 16'h4d4a, 16'h2d4a, 16'had4a, 16'h354a, 16'hb54a, 16'hd54a, 16'h554a,
        16'h332a, 16'hb32a, 16'hd32a, 16'h532a, 16'hcb2a, 16'h4b2a, 16'h2b2a, 16'hab2a,
        16'hcd2a, 16'h4d2a, 16'h2d2a, 16'had2a, 16'h352a, 16'hb52a, 16'hd52a, 16'h552a,
        16'hccaa, 16'h4caa, 16'h2caa, 16'hacaa, 16'h34aa, 16'hb4aa, 16'hd4aa, 16'h54aa,
        16'h32aa, 16'hb2aa, 16'hd2aa, 16'h52aa, 16'hcaaa, 16'h4aaa, 16'h2aaa, 16'haaaa
    };

endpackage

@@ design/sfe_lane.sv @@
// One channel lane: Q16 gain multiply, registered, then biphase-mark encoding.
module sfe_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic signed [sfe_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sfe_pkg::GAIN_W-1:0]    i_gain,
    output logic [sfe_pkg::WORD_W-1:0]    o_data_word,
    output logic [sfe_pkg::AUX_W-1:0]     o_aux
);
    import sfe_pkg::*;

    logic signed [SAMPLE_W+GAIN_W-1:0] w_product;
    logic [SAMPLE_W-1:0]               r_scaled;
    logic [15:0]                       w_hi;
    logic [15:0]                       w_lo;

    // Signed sample times unsigned gain; low 32 bits match the 32-bit wrap
    assign w_product = (SAMPLE_W+GAIN_W)'(i_sample)
                     * (SAMPLE_W+GAIN_W)'($signed({1'b0, i_gain}));

    // Scaled sample register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_scaled <= w_product[31:16];
        end
    end

    // Encode both bytes, invert low half when high half ends low
    always_comb begin
        w_hi = BMC_TABLE[r_scaled[15:8]];
        w_lo = BMC_TABLE[r_scaled[7:0]];
        if (!w_hi[15]) begin
            w_lo = ~w_lo;
        end
        o_data_word = {w_lo, w_hi};
        o_aux       = w_lo[15] ? (AUX_BITS ^ AUX_FLIP) : AUX_BITS;
    end

endmodule

@@ design/sfe_merge.sv @@
// Merges the two lane results with preambles into the registered output request.
module sfe_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sfe_pkg::t_frame_ctl        i_ctl,
    input  logic [sfe_pkg::WORD_W-1:0] i_left_data,
    input  logic [sfe_pkg::AUX_W-1:0]  i_left_aux,
    input  logic [sfe_pkg::WORD_W-1:0] i_right_data,
    input  logic [sfe_pkg::AUX_W-1:0]  i_right_aux,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [4*sfe_pkg::WORD_W-1:0] o_tdata,
    output logic                       o_tlast
);
    import sfe_pkg::*;

    logic                  r_valid;
    logic [4*WORD_W-1:0]   r_tdata;
    logic                  r_tlast;
    logic [WORD_W-1:0]     w_left_pre;
    logic [WORD_W-1:0]     w_right_pre;

    assign o_ready = !r_valid || i_tready;

    // Preamble words with aux bits in the low half
    assign w_left_pre  = (i_ctl.block_start ? PRE_B : PRE_M) | {16'h0000, i_left_aux};
    assign w_right_pre = PRE_W | {16'h0000, i_right_aux};

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tdata <= {w_right_pre, i_right_data, w_left_pre, i_left_data};
            r_tlast <= i_ctl.chunk_end;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

@@ design/spdif_frame_encoder.sv @@
// Top level of the S/PDIF stereo frame encoder.
// One stereo frame in per cycle, one set of four subframe words out per cycle, while
// m_axis_tready does not hold the output back. An input request passes the gain multiply
// register, then is encoded into the output register. Each channel has its own 16x17
// multiplier and table lookup. The gain register is written through the cfg channel, which
// is always ready; write it only while idle. The frame counter resets to zero and wraps
// after BLOCK_FRAMES frames; frame zero gets preamble B on the left subframe.
module spdif_frame_encoder #(
    parameter int BLOCK_FRAMES = 192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: gain register
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [16:0]  i_cfg_data,
    // Input frames
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic         s_axis_tlast,   // chunk_end
    // Output subframes
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [31:0] left_data_word, [63:32] left_preamble_word,
                                         // [95:64] right_data_word, [127:96] right_preamble_word
    output logic         m_axis_tlast    // chunk_end_out
);
    import sfe_pkg::*;

    localparam int CNT_W = (BLOCK_FRAMES > 2) ? $clog2(BLOCK_FRAMES) : 1;
    localparam logic [CNT_W-1:0] LAST_FRAME = CNT_W'(BLOCK_FRAMES - 1);

    logic [GAIN_W-1:0] r_gain;
    logic [CNT_W-1:0]  r_frame_cnt;
    logic [CNT_W-1:0]  n_frame_cnt;
    logic              r_s1_valid;
    t_frame_ctl        r_s1_ctl;
    logic              w_merge_ready;
    logic              w_accept;
    logic [WORD_W-1:0] w_left_data;
    logic [AUX_W-1:0]  w_left_aux;
    logic [WORD_W-1:0] w_right_data;
    logic [AUX_W-1:0]  w_right_aux;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_s1_valid || w_merge_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= UNITY_GAIN;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // Frame counter within the block
    assign n_frame_cnt = (r_frame_cnt == LAST_FRAME) ? '0 : r_frame_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
        end else if (w_accept) begin
            r_frame_cnt <= n_frame_cnt;
        end
    end

    // Multiply stage valid and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ctl.block_start <= (r_frame_cnt == '0);
            r_s1_ctl.chunk_end   <= s_axis_tlast;
        end
    end

    // Channel lanes
    sfe_lane u_lane_left (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_sample    ($signed(s_axis_tdata[15:0])),
        .i_gain      (r_gain),
        .o_data_word (w_left_data),
        .o_aux       (w_left_aux)
    );

    sfe_lane u_lane_right (
        .i_clk       (i_clk),
        .i_load      (w_accept),
        .i_sample    ($signed(s_axis_tdata[31:16])),
        .i_gain      (r_gain),
        .o_data_word (w_right_data),
        .o_aux       (w_right_aux)
    );

    // Merge and output register
    sfe_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s1_valid),
        .o_ready      (w_merge_ready),
        .i_ctl        (r_s1_ctl),
        .i_left_data  (w_left_data),
        .i_left_aux   (w_left_aux),
        .i_right_data (w_right_data),
        .i_right_aux  (w_right_aux),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

endmodule
